// File: design/cva_pkg.sv
// shared types and constants for the checked four-lane 64-bit integer alu
// no dependencies
package cva_pkg;

	localparam int unsigned LANES   = 4;
	localparam int unsigned LAT     = 66;
	localparam int unsigned MUL_STG = 5;
	localparam logic [63:0] S64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MINUS_ONE = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_NEG = 3'd4;
	localparam logic [2:0] OP_DOT = 3'd5;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [63:0] a_x;
		logic signed [63:0] a_y;
		logic signed [63:0] a_z;
		logic signed [63:0] a_w;
		logic signed [63:0] b_x;
		logic signed [63:0] b_y;
		logic signed [63:0] b_z;
		logic signed [63:0] b_w;
	} req_item_t;

	typedef struct packed {
		logic signed [63:0] result_x;
		logic signed [63:0] result_y;
		logic signed [63:0] result_z;
		logic signed [63:0] result_w;
		logic               status;
	} rsp_item_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] a;
		logic [63:0] res;
		logic        err;
	} lane_out_t;

endpackage

// File: design/checked_vec4_integer_alu.sv
// top level: four lanes side by side and a three-stage merge for the dot sum
// depends on cva_pkg and cva_lane
//
//  channel | valid     | stall     | payload
//  request | req_valid | req_stall | req_data (operation, a, b)
//  result  | rsp_valid | rsp_stall | rsp_data (results, status)
//
// every item passes 69 register stages, the last of which is the result register
// the depth is one input stage, the 64-stage divider and a sign stage per lane,
// plus three merge stages
// one item may enter every cycle; a stalled result freezes the whole pipe
// reset clears only the valid bits
module checked_vec4_integer_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  cva_pkg::req_item_t req_data,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output cva_pkg::rsp_item_t rsp_data
);
	import cva_pkg::*;

	localparam int unsigned DEPTH = LAT + 3;

	logic      adv;
	logic      vld_q [1:DEPTH];
	lane_out_t lo [LANES];
	logic [63:0] av [LANES];
	logic [63:0] bv [LANES];

	assign adv       = !(vld_q[DEPTH] && rsp_stall);
	assign req_stall = !adv;
	assign rsp_valid = vld_q[DEPTH];

	assign av[0] = req_data.a_x;
	assign av[1] = req_data.a_y;
	assign av[2] = req_data.a_z;
	assign av[3] = req_data.a_w;
	assign bv[0] = req_data.b_x;
	assign bv[1] = req_data.b_y;
	assign bv[2] = req_data.b_z;
	assign bv[3] = req_data.b_w;

	genvar i;
	generate
		for (i = 0; i < LANES; i++) begin : g_lane
			cva_lane u_lane (
				.clk (clk),
				.adv (adv),
				.op  (req_data.operation),
				.a   (av[i]),
				.b   (bv[i]),
				.lo  (lo[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 1; n <= DEPTH; n++) vld_q[n] <= 1'b0;
		end else if (adv) begin
			vld_q[1] <= req_valid;
			for (int n = 2; n <= DEPTH; n++) vld_q[n] <= vld_q[n-1];
		end
	end

	logic [2:0]  op_m1, op_m2;
	logic [63:0] a_m1 [LANES];
	logic [63:0] a_m2 [LANES];
	logic [63:0] r_m1 [LANES];
	logic [63:0] r_m2 [LANES];
	logic [63:0] sum_m1, sum_m2;
	logic        err_m1, err_m2;
	rsp_item_t   out_q;
	logic [2:0]  op_q;

	logic [63:0] s1, s2, s3;
	logic        o1, o2, o3, dot0, dot1, dot2, any_err;

	always_comb begin
		any_err = lo[0].err | lo[1].err | lo[2].err | lo[3].err;
		dot0 = (lo[0].op == OP_DOT);
		dot1 = (op_m1 == OP_DOT);
		dot2 = (op_m2 == OP_DOT);
		s1 = lo[0].res + lo[1].res;
		o1 = (lo[0].res[63] ^ s1[63]) & (lo[1].res[63] ^ s1[63]);
		s2 = sum_m1 + r_m1[2];
		o2 = (sum_m1[63] ^ s2[63]) & (r_m1[2][63] ^ s2[63]);
		s3 = sum_m2 + r_m2[3];
		o3 = (sum_m2[63] ^ s3[63]) & (r_m2[3][63] ^ s3[63]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_m1  <= lo[0].op;
			sum_m1 <= s1;
			err_m1 <= any_err | (dot0 & o1);
			op_m2  <= op_m1;
			sum_m2 <= s2;
			err_m2 <= err_m1 | (dot1 & o2);
			for (int n = 0; n < LANES; n++) begin
				a_m1[n] <= lo[n].a;
				r_m1[n] <= lo[n].res;
				a_m2[n] <= a_m1[n];
				r_m2[n] <= r_m1[n];
			end
			op_q <= op_m2;
			if (err_m2 | (dot2 & o3)) begin
				out_q.result_x <= a_m2[0];
				out_q.result_y <= a_m2[1];
				out_q.result_z <= a_m2[2];
				out_q.result_w <= a_m2[3];
				out_q.status   <= 1'b1;
			end else if (dot2) begin
				out_q.result_x <= s3;
				out_q.result_y <= '0;
				out_q.result_z <= '0;
				out_q.result_w <= '0;
				out_q.status   <= 1'b0;
			end else begin
				out_q.result_x <= r_m2[0];
				out_q.result_y <= r_m2[1];
				out_q.result_z <= r_m2[2];
				out_q.result_w <= r_m2[3];
				out_q.status   <= 1'b0;
			end
		end
	end

	assign rsp_data = out_q;

	a_stall_tie: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall == (rsp_valid && rsp_stall))
		else $error("request stall does not follow result stall");

	a_bad_op: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && op_q > OP_DOT) |-> rsp_data.status)
		else $error("unknown operation not flagged");

	a_dot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && op_q == OP_DOT && !rsp_data.status) |->
		(rsp_data.result_y == '0 && rsp_data.result_z == '0 && rsp_data.result_w == '0))
		else $error("dot result with nonzero upper lanes");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> $stable(op_q))
		else $error("pipeline moved while stalled");

endmodule

// File: design/cva_lane.sv
// one 64-bit lane: add, subtract, negate, pipelined multiply and radix-2 divider
// depends on cva_pkg
module cva_lane (
	input  logic              clk,
	input  logic              adv,
	input  logic [2:0]        op,
	input  logic [63:0]       a,
	input  logic [63:0]       b,
	output cva_pkg::lane_out_t lo
);
	import cva_pkg::*;

	logic [2:0]  op_s  [1:LAT];
	logic [63:0] a_s   [1:LAT];
	logic [63:0] r_s   [1:LAT];
	logic        e_s   [1:LAT];
	logic        neg_s [1:LAT];
	logic [63:0] dr_s  [1:LAT-1];
	logic [63:0] dq_s  [1:LAT-1];
	logic [63:0] dd_s  [1:LAT-1];

	logic [63:0] pp_ll_s2, pp_lh_s2, pp_hl_s2, pp_hh_s2;
	logic [64:0] mid_s3;
	logic [63:0] ll_s3, hh_s3;
	logic [127:0] prod_s4;

	logic [63:0] ma, mb, sum, dif, ngt, rc;
	logic        ec;

	always_comb begin
		ma  = a[63] ? (~a + 64'd1) : a;
		mb  = b[63] ? (~b + 64'd1) : b;
		sum = a + b;
		dif = a - b;
		ngt = ~a + 64'd1;
		rc  = '0;
		ec  = 1'b0;
		case (op)
			OP_ADD: begin
				rc = sum;
				ec = (a[63] ^ sum[63]) & (b[63] ^ sum[63]);
			end
			OP_SUB: begin
				rc = dif;
				ec = (a[63] ^ b[63]) & (a[63] ^ dif[63]);
			end
			OP_MUL, OP_DOT: begin
				ec = 1'b0;
			end
			OP_DIV: begin
				ec = (b == '0) || (a == S64_MIN && b == MINUS_ONE);
			end
			OP_NEG: begin
				rc = ngt;
				ec = (a == S64_MIN);
			end
			default: begin
				ec = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s[1]  <= op;
			a_s[1]   <= a;
			r_s[1]   <= rc;
			e_s[1]   <= ec;
			neg_s[1] <= a[63] ^ b[63];
			dq_s[1]  <= ma;
			dd_s[1]  <= mb;
			dr_s[1]  <= '0;
		end
	end

	// multiplier: 32x32 partial products, then two adds
	always_ff @(posedge clk) begin
		if (adv) begin
			pp_ll_s2 <= dq_s[1][31:0] * dd_s[1][31:0];
			pp_lh_s2 <= dq_s[1][31:0] * dd_s[1][63:32];
			pp_hl_s2 <= dq_s[1][63:32] * dd_s[1][31:0];
			pp_hh_s2 <= dq_s[1][63:32] * dd_s[1][63:32];
			mid_s3   <= {1'b0, pp_lh_s2} + {1'b0, pp_hl_s2};
			ll_s3    <= pp_ll_s2;
			hh_s3    <= pp_hh_s2;
			prod_s4  <= {hh_s3, ll_s3} + {31'd0, mid_s3, 32'd0};
		end
	end

	logic [127:0] limit;
	logic         mul_ovf;
	logic [63:0]  mul_res;
	logic [63:0]  quo;

	always_comb begin
		limit   = neg_s[MUL_STG-1] ? {64'd0, S64_MIN} : {64'd0, S64_MAX};
		mul_ovf = prod_s4 > limit;
		mul_res = neg_s[MUL_STG-1] ? (~prod_s4[63:0] + 64'd1) : prod_s4[63:0];
		quo     = neg_s[LAT-1] ? (~dq_s[LAT-1] + 64'd1) : dq_s[LAT-1];
	end

	genvar k;
	generate
		for (k = 2; k <= LAT; k++) begin : g_stg
			logic [63:0] r_n;
			logic        e_n;
			always_comb begin
				r_n = r_s[k-1];
				e_n = e_s[k-1];
				if (k == MUL_STG && (op_s[k-1] == OP_MUL || op_s[k-1] == OP_DOT)) begin
					r_n = mul_res;
					e_n = mul_ovf;
				end
				if (k == LAT && op_s[k-1] == OP_DIV) begin
					r_n = quo;
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					op_s[k]  <= op_s[k-1];
					a_s[k]   <= a_s[k-1];
					neg_s[k] <= neg_s[k-1];
					r_s[k]   <= r_n;
					e_s[k]   <= e_n;
				end
			end
		end

		// restoring divider, one quotient bit per stage
		for (k = 2; k <= LAT - 1; k++) begin : g_div
			logic [64:0] shr;
			logic [64:0] trial;
			always_comb begin
				shr   = {dr_s[k-1], dq_s[k-1][63]};
				trial = shr - {1'b0, dd_s[k-1]};
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					dr_s[k] <= trial[64] ? shr[63:0] : trial[63:0];
					dq_s[k] <= {dq_s[k-1][62:0], ~trial[64]};
					dd_s[k] <= dd_s[k-1];
				end
			end
		end
	endgenerate

	assign lo.op  = op_s[LAT];
	assign lo.a   = a_s[LAT];
	assign lo.res = r_s[LAT];
	assign lo.err = e_s[LAT];

endmodule

// File: sim/testbench.sv
// testbench for checked_vec4_integer_alu: directed and random vector items, self-checking
// depends on cva_pkg and the alu rtl; results are predicted per item and compared in order
`timescale 1ns / 1ps

module testbench;
	import cva_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_item_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_item_t rsp_data;

	rsp_item_t alu_expected[$];
	int errors = 0;
	int sent = 0;
	int received = 0;
	int hold_cycles = 0;
	bit rsp_random = 1'b1;

	checked_vec4_integer_alu DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
	);

	always #10 clk = ~clk;

	function automatic logic signed [63:0] lane_get(input logic [255:0] v, input int i);
		return v[255 - 64 * i -: 64];
	endfunction

	function automatic rsp_item_t alu_predict(input req_item_t it);
		logic [255:0] av, bv;
		logic signed [63:0] a, b, r[4];
		logic signed [129:0] ex, acc;
		logic err;
		rsp_item_t o;
		av = {it.a_x, it.a_y, it.a_z, it.a_w};
		bv = {it.b_x, it.b_y, it.b_z, it.b_w};
		err = 1'b0;
		acc = '0;
		for (int i = 0; i < 4; i++) begin
			a = lane_get(av, i);
			b = lane_get(bv, i);
			r[i] = '0;
			ex = '0;
			case (it.operation)
				OP_ADD: ex = 130'(a) + 130'(b);
				OP_SUB: ex = 130'(a) - 130'(b);
				OP_MUL, OP_DOT: ex = 130'(a) * 130'(b);
				OP_DIV: begin
					if (b == 0 || (a == S64_MIN && b == MINUS_ONE))
						ex = 130'sh1_0000_0000_0000_0000;
					else
						ex = 130'(a / b);
				end
				OP_NEG: ex = -130'(a);
				default: err = 1'b1;
			endcase
			if (ex > 130'(signed'(S64_MAX)) || ex < 130'(signed'(S64_MIN)))
				err = 1'b1;
			r[i] = ex[63:0];
			if (it.operation == OP_DOT && i > 0 && !err) begin
				acc = 130'(signed'(acc[63:0])) + 130'(signed'(r[i]));
				if (acc > 130'(signed'(S64_MAX)) || acc < 130'(signed'(S64_MIN)))
					err = 1'b1;
			end else if (i == 0)
				acc = ex;
		end
		if (it.operation == OP_DOT) begin
			r[0] = acc[63:0];
			r[1] = '0; r[2] = '0; r[3] = '0;
		end
		if (err)
			o = '{it.a_x, it.a_y, it.a_z, it.a_w, 1'b1};
		else
			o = '{r[0], r[1], r[2], r[3], 1'b0};
		return o;
	endfunction

	task automatic send_item(input req_item_t it);
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		alu_expected.push_back(alu_predict(it));
		sent++;
	endtask

	function automatic logic signed [63:0] rand_value();
		logic [63:0] v;
		case ($urandom_range(0, 9))
			0: v = S64_MAX;
			1: v = S64_MIN;
			2: v = MINUS_ONE;
			3: v = '0;
			4: v = 64'($urandom_range(0, 20)) - 64'd10;
			5: v = {{32{1'b0}}, $urandom()};
			6: v = {{33{$urandom_range(0, 1) == 1}}, 31'($urandom())};
			default: v = {$urandom(), $urandom()};
		endcase
		return v;
	endfunction

	function automatic req_item_t rand_item(input logic [2:0] op);
		req_item_t it;
		it.operation = op;
		it.a_x = rand_value(); it.a_y = rand_value();
		it.a_z = rand_value(); it.a_w = rand_value();
		it.b_x = rand_value(); it.b_y = rand_value();
		it.b_z = rand_value(); it.b_w = rand_value();
		return it;
	endfunction

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (alu_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		req_item_t it;
		for (int op = 0; op < 8; op++) begin
			it = '{3'(op), S64_MAX, S64_MIN, MINUS_ONE, 64'sd7,
				64'sd1, MINUS_ONE, MINUS_ONE, -64'sd2};
			send_item(it);
			it = '{3'(op), 64'sd100, -64'sd7, 64'sd3, 64'sd0,
				64'sd9, 64'sd2, -64'sd3, 64'sd5};
			send_item(it);
		end
		// dot with partial sum overflowing then returning
		send_item('{OP_DOT, S64_MAX, 64'sd1, -64'sd1, 64'sd0,
			64'sd1, 64'sd1, 64'sd1, 64'sd0});
		send_item('{OP_DOT, 64'sh4000_0000_0000_0000, 64'sd2, 64'sd0, 64'sd0,
			64'sd2, 64'sh2000_0000_0000_0000, 64'sd0, 64'sd0});
		send_item('{OP_MUL, S64_MIN, 64'sh1_0000_0000, 64'sh8000_0000, MINUS_ONE,
			64'sd1, 64'sh8000_0000, -64'sh1_0000_0000, S64_MIN});
		send_item('{OP_NEG, 64'sd5, -64'sd5, S64_MAX, 64'sd0,
			'0, '0, '0, '0});
		send_item('{OP_DIV, -64'sd7, 64'sd7, S64_MIN, S64_MIN,
			64'sd2, -64'sd2, 64'sd2, S64_MIN});
		send_item('1);
		send_item('0);
		wait_drained();
	endtask

	task automatic test_random(input int count);
		for (int n = 0; n < count; n++)
			send_item(rand_item(3'($urandom_range(0, 5) + ($urandom_range(0, 19) == 0 ? 2 : 0))));
	endtask

	task automatic test_backpressure();
		req_item_t it;
		rsp_random = 1'b0;
		hold_cycles = 200;
		for (int n = 0; n < 120; n++) begin
			it = rand_item(3'($urandom_range(0, 5)));
			req_valid <= 1'b1;
			req_data <= it;
			@(posedge clk);
			while (req_stall)
				@(posedge clk);
			alu_expected.push_back(alu_predict(it));
			sent++;
		end
		rsp_random = 1'b1;
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(900);
		test_backpressure();
		test_random(800);
		wait_drained();
		repeat (3 * LAT) @(posedge clk);
		$display("sent %0d items, checked %0d results, incl. back-pressure fill", sent, received);
		if (errors == 0 && alu_expected.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// receiver stall: random gaps, or a long counted hold
	initial begin
		int gap;
		forever begin
			if (hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
				rsp_stall <= 1'b0;
				@(posedge clk);
			end else if (rsp_random && $urandom_range(0, 2) == 0) begin
				gap = $urandom_range(0, 9);
				if (gap > 0) begin
					rsp_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
				rsp_stall <= 1'b0;
				@(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		rsp_item_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			received++;
			if (alu_expected.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = alu_expected.pop_front();
				if (rsp_data.result_x !== e.result_x) begin
					$error("result_x expected %h actual %h", e.result_x, rsp_data.result_x);
					errors++;
				end
				if (rsp_data.result_y !== e.result_y) begin
					$error("result_y expected %h actual %h", e.result_y, rsp_data.result_y);
					errors++;
				end
				if (rsp_data.result_z !== e.result_z) begin
					$error("result_z expected %h actual %h", e.result_z, rsp_data.result_z);
					errors++;
				end
				if (rsp_data.result_w !== e.result_w) begin
					$error("result_w expected %h actual %h", e.result_w, rsp_data.result_w);
					errors++;
				end
				if (rsp_data.status !== e.status) begin
					$error("status expected %b actual %b", e.status, rsp_data.status);
					errors++;
				end
			end
		end
	end

	initial begin
		#100ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: filelist.f
design/cva_pkg.sv
design/cva_lane.sv
design/checked_vec4_integer_alu.sv
sim/testbench.sv
